// ----- rtl/wzh_pkg.sv -----
// Shared constants, command and status codes and cell control type for the window hit-test block
package wzh_pkg;

  localparam int NUM_WINDOWS_DEF = 16;
  localparam int COORD_BITS_DEF  = 12;

  localparam int CMD_W      = 3;
  localparam int SEL_W      = 4;
  localparam int PT_W       = 12;
  localparam int FLAGS_W    = 2;
  localparam int ATTR_W     = 3;
  localparam int TITLE_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;

  localparam logic [TITLE_W-1:0] TITLE_RESET = 8'd20;

  localparam int X_BASE  = 30;
  localparam int X_STEP  = 40;
  localparam int Y_BASE  = 50;
  localparam int Y_STEP  = 35;
  localparam int FRAME_W = 2;
  localparam int FRAME_H = 1;

  localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FRONT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESIZE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SWAP    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_HIT     = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  typedef struct packed {
    logic load;
    logic shift_dn;
    logic shift_up;
    logic resize;
    logic swap;
  } wzh_cell_ctl_t;

endpackage

// ----- rtl/wzh_cell.sv -----
// One z-order position: holds a window record, compares it with the current request
module wzh_cell #(
  parameter int COORD_BITS = wzh_pkg::COORD_BITS_DEF,
  parameter int SLOT_W     = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wzh_pkg::wzh_cell_ctl_t               ctl_i,
  input  logic                                 occ_prev_i,
  input  logic [wzh_pkg::ATTR_W+4*COORD_BITS+SLOT_W-1:0] rec_prev_i,
  input  logic                                 occ_next_i,
  input  logic [wzh_pkg::ATTR_W+4*COORD_BITS+SLOT_W-1:0] rec_next_i,
  input  logic [wzh_pkg::ATTR_W+4*COORD_BITS+SLOT_W-1:0] rec_load_i,
  input  logic [SLOT_W-1:0]                    sel_id_i,
  input  logic [COORD_BITS-1:0]                nw_i,
  input  logic [COORD_BITS-1:0]                nh_i,
  input  logic [wzh_pkg::PT_W-1:0]             px_i,
  input  logic [wzh_pkg::PT_W-1:0]             py_i,
  input  logic [wzh_pkg::TITLE_W-1:0]          title_i,
  output logic                                 occ_o,
  output logic [wzh_pkg::ATTR_W+4*COORD_BITS+SLOT_W-1:0] rec_o,
  output logic                                 match_o,
  output logic                                 hit_o,
  output logic                                 inc_o
);
  import wzh_pkg::*;

  localparam int REC_W = ATTR_W + 4*COORD_BITS + SLOT_W;
  localparam int X_LO  = SLOT_W;
  localparam int Y_LO  = SLOT_W + COORD_BITS;
  localparam int W_LO  = SLOT_W + 2*COORD_BITS;
  localparam int H_LO  = SLOT_W + 3*COORD_BITS;
  localparam int A_LO  = SLOT_W + 4*COORD_BITS;
  localparam int CMP_W = ((COORD_BITS > PT_W) ? COORD_BITS : PT_W) + 2;

  logic             occ_r, occ_nxt;
  logic [REC_W-1:0] rec_r, rec_nxt;
  logic             match_r, match_nxt;
  logic             hit_r, hit_nxt;
  logic             inc_r, inc_nxt;

  logic [ATTR_W-1:0] attr;
  logic [CMP_W-1:0]  xe, ye, we, he, pxe, pye, te, right_e, bottom_e, top_c, bot_c;

  assign attr = rec_r[A_LO +: ATTR_W];

  always_comb begin
    occ_nxt = occ_r;
    rec_nxt = rec_r;
    if (ctl_i.load) begin
      occ_nxt = 1'b1;
      rec_nxt = rec_load_i;
    end else if (ctl_i.shift_dn) begin
      occ_nxt = occ_prev_i;
      rec_nxt = rec_prev_i;
    end else if (ctl_i.shift_up) begin
      occ_nxt = occ_next_i;
      rec_nxt = rec_next_i;
    end else if (match_r && ctl_i.resize) begin
      rec_nxt[W_LO +: COORD_BITS] = nw_i;
      rec_nxt[H_LO +: COORD_BITS] = nh_i;
    end else if (match_r && ctl_i.swap && attr[0]) begin
      rec_nxt[A_LO+2] = ~attr[2];
    end
  end

  // outer rectangle and content band against the request point
  always_comb begin
    xe       = CMP_W'(rec_r[X_LO +: COORD_BITS]);
    ye       = CMP_W'(rec_r[Y_LO +: COORD_BITS]);
    we       = CMP_W'(rec_r[W_LO +: COORD_BITS]);
    he       = CMP_W'(rec_r[H_LO +: COORD_BITS]);
    pxe      = CMP_W'(px_i);
    pye      = CMP_W'(py_i);
    te       = CMP_W'(title_i);
    right_e  = xe + we + CMP_W'(FRAME_W);
    bottom_e = ye + he + te + CMP_W'(FRAME_H);
    top_c    = ye + te;
    bot_c    = ye + he;
    match_nxt = occ_r && (rec_r[SLOT_W-1:0] == sel_id_i);
    hit_nxt   = occ_r && (xe <= pxe) && (ye <= pye) && (pxe <= right_e) && (pye <= bottom_e);
    inc_nxt   = (pye > top_c) && (pye < bot_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= 1'b0;
      match_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      occ_r   <= occ_nxt;
      match_r <= match_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    inc_r <= inc_nxt;
  end

  assign occ_o   = occ_r;
  assign rec_o   = rec_r;
  assign match_o = match_r;
  assign hit_o   = hit_r;
  assign inc_o   = inc_r;

endmodule

// ----- rtl/window_zorder_hit_test_core.sv -----
// Window table with front-to-back z-order and point hit test, top level
// The z-order is a row of NUM_WINDOWS cells, front first; each cell holds one window's slot,
// position, size and attributes and shifts it to a neighbour on create, destroy and
// move-to-front. A request passes from acceptance through an execute state, in which
// all cells compare against the target slot and the point in parallel, and an update state,
// in which the row shifts or updates and the result is registered, before the next ready.
// A result still held on the output does not block acceptance, only the update stage.
// Reset needs no sweep.
module window_zorder_hit_test_core #(
  parameter int NUM_WINDOWS = wzh_pkg::NUM_WINDOWS_DEF,
  parameter int COORD_BITS  = wzh_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // window_sel, new_width, new_height, win_flags, point_x, point_y
  input  logic [wzh_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd
  input  logic [wzh_pkg::CMD_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // window_out, found, in_content, buffer_shown, focus_window, status
  output logic [wzh_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [wzh_pkg::TITLE_W-1:0]     cfg_wr_data
);
  import wzh_pkg::*;

  localparam int N      = NUM_WINDOWS;
  localparam int SLOT_W = (N > 2) ? $clog2(N) : 1;
  localparam int IDX_W  = (SLOT_W > SEL_W) ? SLOT_W : SEL_W;
  localparam int REC_W  = ATTR_W + 4*COORD_BITS + SLOT_W;
  localparam int A_LO   = SLOT_W + 4*COORD_BITS;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_APPLY} state_t;

  state_t                 state_r, state_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic [N-1:0]           valid_r, valid_nxt;
  logic                   focus_on_r, focus_on_nxt;
  logic [SLOT_W-1:0]      focus_id_r, focus_id_nxt;
  logic [TITLE_W-1:0]     title_r;

  logic [CMD_W-1:0]       cmd_r;
  logic [SEL_W-1:0]       sel_r;
  logic [PT_W-1:0]        nw_r, nh_r, px_r, py_r;
  logic [FLAGS_W-1:0]     fl_r;

  logic                   in_acc, apply_go;
  logic [IDX_W:0]         sel_wide;
  logic [SLOT_W-1:0]      sel_id;
  logic                   sel_ok;

  logic [N-1:0]           occ_v, match_v, hit_v, inc_v, occ_prev, occ_next;
  logic [REC_W-1:0]       rec_v [N];
  logic [REC_W-1:0]       rec_prev [N];
  logic [REC_W-1:0]       rec_next [N];
  wzh_cell_ctl_t          op_ctl [N];
  wzh_cell_ctl_t          ctl_a [N];

  logic [N-1:0]           pre_incl, pre_excl, pfx_msk;
  logic [N-1:0]           free_oh, hit_oh;
  logic [SLOT_W-1:0]      free_id, hit_id;
  logic                   full, hit_inc;
  logic [REC_W-1:0]       sel_rec, new_rec, ld_rec;
  logic [ATTR_W-1:0]      sel_attr;
  logic [31:0]            x_full, y_full;
  logic [COORD_BITS-1:0]  nw_c, nh_c;

  logic [SEL_W-1:0]       res_wout;
  logic                   res_found, res_inc, res_shown;
  logic [STATUS_W-1:0]    res_status;
  logic [N-1:0]           op_valid;
  logic                   op_focus_on;
  logic [SLOT_W-1:0]      op_focus_id;

  function automatic logic [SEL_W-1:0] id4(input logic [SLOT_W-1:0] id);
    logic [IDX_W-1:0] w;
    w = IDX_W'(id);
    return w[SEL_W-1:0];
  endfunction

  function automatic logic [N-1:0] free_oh_mask(input logic [SLOT_W-1:0] id);
    logic [N-1:0] m;
    for (int i = 0; i < N; i++) m[i] = (SLOT_W'(i) == id);
    return m;
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign apply_go   = (state_r == S_APPLY) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  assign sel_wide = (IDX_W+1)'(sel_r);
  assign sel_id   = sel_wide[SLOT_W-1:0];
  assign sel_ok   = (sel_wide < (IDX_W+1)'(N)) && valid_r[sel_id];
  assign nw_c     = COORD_BITS'(nw_r);
  assign nh_c     = COORD_BITS'(nh_r);

  // neighbour links of the cell row
  assign occ_prev = {occ_v[N-2:0], 1'b0};
  assign occ_next = {1'b0, occ_v[N-1:1]};
  always_comb begin
    rec_prev[0]   = '0;
    rec_next[N-1] = '0;
    for (int i = 1; i < N; i++) rec_prev[i] = rec_v[i-1];
    for (int i = 0; i < N-1; i++) rec_next[i] = rec_v[i+1];
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      wzh_cell #(
        .COORD_BITS (COORD_BITS),
        .SLOT_W     (SLOT_W)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_i      (ctl_a[g]),
        .occ_prev_i (occ_prev[g]),
        .rec_prev_i (rec_prev[g]),
        .occ_next_i (occ_next[g]),
        .rec_next_i (rec_next[g]),
        .rec_load_i (ld_rec),
        .sel_id_i   (sel_id),
        .nw_i       (nw_c),
        .nh_i       (nh_c),
        .px_i       (px_r),
        .py_i       (py_r),
        .title_i    (title_r),
        .occ_o      (occ_v[g]),
        .rec_o      (rec_v[g]),
        .match_o    (match_v[g]),
        .hit_o      (hit_v[g]),
        .inc_o      (inc_v[g])
      );
    end
  endgenerate

  // positions at or behind the target, lowest free slot, frontmost hit
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) pfx_msk[j] = (j <= i);
      pre_incl[i] = |(match_v & pfx_msk);
    end
    pre_excl = pre_incl & ~match_v;
    full     = &valid_r;
    free_oh  = ~valid_r & (valid_r + N'(1));
    hit_oh   = hit_v & (~hit_v + N'(1));
    free_id  = '0;
    hit_id   = '0;
    sel_rec  = '0;
    for (int i = 0; i < N; i++) begin
      if (free_oh[i]) free_id = free_id | SLOT_W'(i);
      if (hit_oh[i])  hit_id  = hit_id | rec_v[i][SLOT_W-1:0];
      if (match_v[i]) sel_rec = sel_rec | rec_v[i];
    end
    hit_inc  = |(hit_oh & inc_v);
    sel_attr = sel_rec[A_LO +: ATTR_W];
    x_full   = 32'(X_BASE) + 32'(X_STEP) * 32'(free_id);
    y_full   = 32'(Y_BASE) + 32'(Y_STEP) * 32'(free_id);
    new_rec  = {ATTR_W'(fl_r), nh_c, nw_c, COORD_BITS'(y_full), COORD_BITS'(x_full), free_id};
  end

  always_comb begin
    for (int i = 0; i < N; i++) op_ctl[i] = '0;
    ld_rec      = new_rec;
    res_wout    = '0;
    res_found   = 1'b0;
    res_inc     = 1'b0;
    res_shown   = 1'b0;
    res_status  = ST_OK;
    op_valid    = valid_r;
    op_focus_on = focus_on_r;
    op_focus_id = focus_id_r;
    unique case (cmd_r) inside
      CMD_CREATE: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          for (int i = 0; i < N; i++) op_ctl[i].shift_dn = 1'b1;
          op_ctl[0].load = 1'b1;
          op_valid       = valid_r | free_oh;
          op_focus_on    = 1'b1;
          op_focus_id    = free_id;
          res_wout       = id4(free_id);
        end
      end
      CMD_DESTROY, CMD_FRONT, CMD_RESIZE, CMD_SWAP: begin
        if (!sel_ok) begin
          res_status = ST_ABSENT;
        end else if (cmd_r == CMD_DESTROY) begin
          for (int i = 0; i < N; i++) op_ctl[i].shift_up = pre_incl[i];
          op_valid = valid_r & ~free_oh_mask(sel_id);
        end else if (cmd_r == CMD_FRONT) begin
          for (int i = 1; i < N; i++) op_ctl[i].shift_dn = ~pre_excl[i];
          op_ctl[0].load = 1'b1;
          ld_rec         = sel_rec;
        end else if (cmd_r == CMD_RESIZE) begin
          for (int i = 0; i < N; i++) op_ctl[i].resize = 1'b1;
        end else begin
          for (int i = 0; i < N; i++) op_ctl[i].swap = 1'b1;
          res_shown = sel_attr[2] ^ sel_attr[0];
        end
      end
      CMD_HIT: begin
        res_found = |hit_v;
        res_wout  = id4(hit_id);
        res_inc   = hit_inc;
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < N; i++) ctl_a[i] = apply_go ? op_ctl[i] : '0;
  end

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    valid_nxt      = valid_r;
    focus_on_nxt   = focus_on_r;
    focus_id_nxt   = focus_id_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_APPLY;
      S_APPLY: begin
        if (apply_go) begin
          state_nxt      = S_IDLE;
          out_tvalid_nxt = 1'b1;
          valid_nxt      = op_valid;
          focus_on_nxt   = op_focus_on;
          focus_id_nxt   = op_focus_id;
          out_data_nxt   = OUT_DATA_W'({res_status,
                                        (op_focus_on ? id4(op_focus_id) : SEL_W'(0)),
                                        res_shown, res_inc, res_found, res_wout});
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      out_data_r   <= '0;
      valid_r      <= '0;
      focus_on_r   <= 1'b0;
      focus_id_r   <= '0;
      title_r      <= TITLE_RESET;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      out_data_r   <= out_data_nxt;
      valid_r      <= valid_nxt;
      focus_on_r   <= focus_on_nxt;
      focus_id_r   <= focus_id_nxt;
      if (cfg_wr_en) title_r <= cfg_wr_data;
    end
  end

  // request fields
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_tuser;
      sel_r <= in_tdata[3:0];
      nw_r  <= in_tdata[15:4];
      nh_r  <= in_tdata[27:16];
      fl_r  <= in_tdata[29:28];
      px_r  <= in_tdata[41:30];
      py_r  <= in_tdata[53:42];
    end
  end

  a_slot_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_v))
    else $error("slot held by more than one z-order cell");

  a_row_matches_table: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ_v) == $countones(valid_r))
    else $error("z-order occupancy differs from slot table");

  a_row_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_v + N'(1)) & occ_v) == '0)
    else $error("gap in z-order row");

  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_APPLY))
    else $error("result raised outside update stage");

endmodule
